[hdl/dsb_pkg.sv]
// Shared types and constants for the debounced setpoint buttons block.
`default_nettype none
package dsb_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 8;
	localparam int POLLS_W = 8;
	localparam int HEIGHT_W = 7;
	localparam int YAW_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_POLLS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LEVELS = 4'd1;

	localparam logic [POLLS_W-1:0] POLLS_RESET = 8'd3;
	localparam logic [NUM_BUTTONS-1:0] NORMAL_RESET = 4'd12;

	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd20;
	localparam logic [HEIGHT_W:0] HEIGHT_STEP = 8'd10;
	localparam logic [HEIGHT_W:0] HEIGHT_MAX = 8'd100;
	localparam logic [YAW_W:0] YAW_STEP = 10'd15;
	localparam logic [YAW_W:0] YAW_FULL = 10'd360;

	localparam int BTN_UP = 0;
	localparam int BTN_DOWN = 1;
	localparam int BTN_LEFT = 2;
	localparam int BTN_RIGHT = 3;

	typedef struct packed {
		logic up_pin;
		logic down_pin;
		logic left_pin;
		logic right_pin;
	} btn_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height_target;
		logic [YAW_W-1:0]    yaw_target;
		logic                up_pressed;
		logic                down_pressed;
		logic                left_pressed;
		logic                right_pressed;
	} res_t;

endpackage
`default_nettype wire

[hdl/dsb_if.sv]
// Channel interfaces: button poll items, setpoint results, configuration writes.
`default_nettype none
interface dsb_btn_if;
	logic          valid;
	logic          ready;
	dsb_pkg::btn_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dsb_res_if;
	logic          valid;
	logic          ready;
	dsb_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dsb_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [dsb_pkg::CFG_IDX_W-1:0]      index;
	logic [dsb_pkg::CFG_DATA_W-1:0]     wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

[hdl/debounced_setpoint_buttons_core.sv]
// Top level: four debounced buttons stepping a height and a yaw setpoint.
//
// Channels: btn takes one poll item per tick with the raw level of the up,
// down, left and right pins. res returns exactly one item per poll: the height
// target (0..100), the yaw target (0..345, step 15) and one press flag per
// button. cfg writes debounce_polls (index 0) and normal_levels (index 1);
// it is always ready; it must be written only while no poll is in flight,
// which the block itself does not enforce. Pipeline: a poll accepted at one
// edge is registered in the input register, then its result is registered at
// the next advancing edge. One poll per cycle is sustained while res is not
// stalled; the button counters and setpoint registers are updated at the
// same advancing edge that loads the result register.
// Reset: debounce_polls 3, normal_levels 12, debounced levels equal to those
// normal levels, counters clear, height 20, yaw 0, no item held.
// Stall: while res is stalled a held result stays put and one more poll is
// taken into the input register; btn.ready then drops until res moves.
`default_nettype none
module debounced_setpoint_buttons_core #(
	parameter int COUNT_WIDTH = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dsb_btn_if.sink    btn,
	dsb_res_if.source  res,
	dsb_cfg_if.sink    cfg
);

	logic [dsb_pkg::POLLS_W-1:0]     polls_q;
	logic [dsb_pkg::NUM_BUTTONS-1:0] normal_q;
	logic [dsb_pkg::POLLS_W-1:0]     thresh;

	logic                            valid_s1;
	dsb_pkg::btn_t                   btn_s1;
	logic                            res_valid_q;
	dsb_pkg::res_t                   res_q;
	logic                            advance;

	logic [dsb_pkg::HEIGHT_W-1:0]    height_q;
	logic [dsb_pkg::YAW_W-1:0]       yaw_q;
	logic [dsb_pkg::NUM_BUTTONS-1:0] raw;
	logic [dsb_pkg::NUM_BUTTONS-1:0] pressed;
	logic [dsb_pkg::HEIGHT_W:0]      h_sum;
	logic [dsb_pkg::HEIGHT_W:0]      h_up;
	logic [dsb_pkg::HEIGHT_W:0]      h_dn;
	logic [dsb_pkg::YAW_W:0]         y_lf;
	logic [dsb_pkg::YAW_W:0]         y_sum;
	logic [dsb_pkg::YAW_W:0]         y_rt;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polls_q <= dsb_pkg::POLLS_RESET;
			normal_q <= dsb_pkg::NORMAL_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				dsb_pkg::REG_DEBOUNCE_POLLS: polls_q <= cfg.wdata;
				dsb_pkg::REG_NORMAL_LEVELS:  normal_q <= cfg.wdata[dsb_pkg::NUM_BUTTONS-1:0];
				default: ;
			endcase
		end
	end

	assign thresh = (polls_q == '0) ? dsb_pkg::POLLS_W'(1) : polls_q;

	assign advance = valid_s1 && (!res_valid_q || res.ready);
	assign btn.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (btn.valid && btn.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (btn.valid && btn.ready) begin
			btn_s1 <= btn.data;
		end
	end

	assign raw[dsb_pkg::BTN_UP] = btn_s1.up_pin;
	assign raw[dsb_pkg::BTN_DOWN] = btn_s1.down_pin;
	assign raw[dsb_pkg::BTN_LEFT] = btn_s1.left_pin;
	assign raw[dsb_pkg::BTN_RIGHT] = btn_s1.right_pin;

	for (genvar b = 0; b < dsb_pkg::NUM_BUTTONS; b++) begin : g_btn
		dsb_debounce #(
			.COUNT_WIDTH (COUNT_WIDTH),
			.RESET_LEVEL (dsb_pkg::NORMAL_RESET[b])
		) u_deb (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (advance),
			.raw     (raw[b]),
			.thresh  (thresh),
			.normal  (normal_q[b]),
			.pressed (pressed[b])
		);
	end

	always_comb begin
		h_sum = {1'b0, height_q} + dsb_pkg::HEIGHT_STEP;
		if (pressed[dsb_pkg::BTN_UP]) begin
			h_up = (h_sum > dsb_pkg::HEIGHT_MAX) ? dsb_pkg::HEIGHT_MAX : h_sum;
		end else begin
			h_up = {1'b0, height_q};
		end
		if (pressed[dsb_pkg::BTN_DOWN]) begin
			h_dn = (h_up >= dsb_pkg::HEIGHT_STEP) ? h_up - dsb_pkg::HEIGHT_STEP : '0;
		end else begin
			h_dn = h_up;
		end
		if (pressed[dsb_pkg::BTN_LEFT]) begin
			y_lf = ({1'b0, yaw_q} >= dsb_pkg::YAW_STEP) ? {1'b0, yaw_q} - dsb_pkg::YAW_STEP
				: {1'b0, yaw_q} + dsb_pkg::YAW_FULL - dsb_pkg::YAW_STEP;
		end else begin
			y_lf = {1'b0, yaw_q};
		end
		y_sum = y_lf + dsb_pkg::YAW_STEP;
		if (pressed[dsb_pkg::BTN_RIGHT]) begin
			y_rt = (y_sum >= dsb_pkg::YAW_FULL) ? y_sum - dsb_pkg::YAW_FULL : y_sum;
		end else begin
			y_rt = y_lf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= dsb_pkg::HEIGHT_RESET;
			yaw_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				height_q <= h_dn[dsb_pkg::HEIGHT_W-1:0];
				yaw_q <= y_rt[dsb_pkg::YAW_W-1:0];
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.height_target <= h_dn[dsb_pkg::HEIGHT_W-1:0];
			res_q.yaw_target <= y_rt[dsb_pkg::YAW_W-1:0];
			res_q.up_pressed <= pressed[dsb_pkg::BTN_UP];
			res_q.down_pressed <= pressed[dsb_pkg::BTN_DOWN];
			res_q.left_pressed <= pressed[dsb_pkg::BTN_LEFT];
			res_q.right_pressed <= pressed[dsb_pkg::BTN_RIGHT];
		end
	end

	assign res.valid = res_valid_q;
	assign res.data = res_q;

endmodule
`default_nettype wire

[hdl/dsb_debounce.sv]
// Counter debouncer for one button, with press detection against its normal level.
`default_nettype none
module dsb_debounce #(
	parameter int   COUNT_WIDTH = 8,
	parameter logic RESET_LEVEL = 1'b0
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           raw,
	input  wire logic [dsb_pkg::POLLS_W-1:0]    thresh,
	input  wire logic                           normal,
	output logic                                pressed
);

	localparam int CMP_W = (COUNT_WIDTH > dsb_pkg::POLLS_W) ? COUNT_WIDTH : dsb_pkg::POLLS_W;

	logic [COUNT_WIDTH-1:0] count_q;
	logic                   level_q;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic                   mismatch;
	logic                   hit;

	always_comb begin
		mismatch = (raw != level_q);
		count_inc = (count_q == {COUNT_WIDTH{1'b1}}) ? count_q : count_q + COUNT_WIDTH'(1);
		hit = CMP_W'(count_inc) >= CMP_W'(thresh);
		pressed = mismatch && hit && (raw != normal);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			level_q <= RESET_LEVEL;
		end else if (en) begin
			if (!mismatch) begin
				count_q <= '0;
			end else if (hit) begin
				count_q <= '0;
				level_q <= raw;
			end else begin
				count_q <= count_inc;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/dsb_checker.sv]
// Port-level checks for the debounced setpoint buttons block, bound to the top level.
`default_nettype none
module dsb_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          btn_valid,
	input wire logic          btn_ready,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire dsb_pkg::res_t res_data
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result valid right after reset");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.height_target <= 7'd100)
		else $error("height target out of range");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.yaw_target < 9'd360)
		else $error("yaw target out of range");

	a_no_result_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid ##1 !(btn_valid && btn_ready) ##1 1'b1 |=> !$rose(res_valid)
			|| $past(btn_valid && btn_ready, 2) || $past(btn_valid && btn_ready, 1))
		else $error("result appeared without an accepted item");

endmodule

bind debounced_setpoint_buttons_core dsb_checker u_dsb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.btn_valid (btn.valid),
	.btn_ready (btn.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
`default_nettype wire
